// ===== hdl/rmnh_pkg.sv =====
// rmnh_pkg: shared types, constants and fixed point helpers for the nearest hit block
// no dependencies
`default_nettype none
package rmnh_pkg;
  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int TWidth     = 31;
  localparam int AddrWidth  = 5;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [TWidth-1:0]            dist_t;

  localparam coord_t VMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t VMin = {1'b1, {(CoordWidth-1){1'b0}}};
  localparam dist_t  TMax = {TWidth{1'b1}};
  localparam int     EpsRaw = ((1 << FracBits) + 5000) / 10000;
  localparam logic [CoordWidth:0] EpsQ = (CoordWidth+1)'((EpsRaw == 0) ? 1 : EpsRaw);

  localparam logic [AddrWidth-3:0] RegOx = 0;
  localparam logic [AddrWidth-3:0] RegOy = 1;
  localparam logic [AddrWidth-3:0] RegOz = 2;
  localparam logic [AddrWidth-3:0] RegDx = 3;
  localparam logic [AddrWidth-3:0] RegDy = 4;
  localparam logic [AddrWidth-3:0] RegDz = 5;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       div_start;
    logic       div_step;
    logic       commit;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } sts_t;

  function automatic coord_t sat_w(input logic signed [CoordWidth+1:0] x);
    if (x > $signed({{2{1'b0}}, VMax})) return VMax;
    if (x < $signed({{2{1'b1}}, VMin})) return VMin;
    return x[CoordWidth-1:0];
  endfunction

  // product shifted right with floor, saturated
  function automatic coord_t fmul(input coord_t a, input coord_t b);
    logic signed [2*CoordWidth-1:0] p;
    logic signed [2*CoordWidth-1:0] s;
    p = a * b;
    s = p >>> FracBits;
    if (s > $signed({{CoordWidth{1'b0}}, VMax})) return VMax;
    if (s < $signed({{CoordWidth{1'b1}}, VMin})) return VMin;
    return s[CoordWidth-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/rmnh_if.sv =====
// rmnh_if: valid/ready channel interfaces for triangles and results
// depends on rmnh_pkg
`default_nettype none
interface rmnh_tri_if;
  logic valid;
  logic ready;
  rmnh_pkg::coord_t a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  logic is_last;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  is_last, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                is_last, output ready);
endinterface

interface rmnh_res_if;
  logic valid;
  logic ready;
  rmnh_pkg::dist_t nearest_t;
  logic any_hit;
  modport source (output valid, nearest_t, any_hit, input ready);
  modport sink (input valid, nearest_t, any_hit, output ready);
endinterface
`default_nettype wire

// ===== hdl/rmnh_ctrl.sv =====
// rmnh_ctrl: sequencer for the triangle test, issues commands to the datapath
// depends on rmnh_pkg
`default_nettype none
module rmnh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          out_busy,
  input  wire rmnh_pkg::sts_t sts,
  output logic               in_ready,
  output rmnh_pkg::cmd_t     cmd
);
  import rmnh_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MATH = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_END  = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  localparam logic [2:0] LastStep = 3'd4;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_MATH;
        end
      end
      S_MATH: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == LastStep) begin
          cnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == 3'd0) begin
          cmd.div_start = 1'b1;
          cnt_nxt = 3'd1;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_done) begin
            cnt_nxt   = '0;
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        if (!(sts.last && out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  a_math_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_MATH) else $error("math not entered");
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_IDLE) else $error("end stuck");
endmodule
`default_nettype wire

// ===== hdl/rmnh_dp.sv =====
// rmnh_dp: Moller-Trumbore datapath with six shared multipliers and a serial divider
// depends on rmnh_pkg
`default_nettype none
module rmnh_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rmnh_pkg::cmd_t    cmd,
  input  wire rmnh_pkg::coord_t  org [3],
  input  wire rmnh_pkg::coord_t  dir [3],
  input  wire rmnh_pkg::coord_t  va [3],
  input  wire rmnh_pkg::coord_t  vb [3],
  input  wire rmnh_pkg::coord_t  vc [3],
  input  wire logic              is_last,
  output rmnh_pkg::sts_t         sts,
  output logic                   res_valid,
  output rmnh_pkg::dist_t        res_t,
  output logic                   res_hit,
  input  wire logic              res_take
);
  import rmnh_pkg::*;

  localparam int IntBits = TWidth - FracBits;
  localparam logic [4:0] DivSteps = 5'(TWidth);

  coord_t e1_r [3], e2_r [3], tv_r [3], pv_r [3], qv_r [3];
  coord_t p0_r [3], p1_r [3];
  coord_t det_r, nu_r, nv_r, nt_r;
  logic   last_r;
  dist_t  best_r, best_nxt;
  logic   hit_r, hit_nxt;
  logic   rej_r;
  // divider
  logic [CoordWidth-1:0]        rem_r;
  logic [TWidth-1:0]            num_r;
  logic [CoordWidth-1:0]        dd_r;
  dist_t                        q_r;
  logic [4:0]                   dcnt_r;
  logic                         dsat_r;
  logic [CoordWidth:0]          rsh;
  logic [CoordWidth:0]          rdif;
  logic                         qbit;
  logic                         div_end;
  dist_t                        t_c;
  logic                         acc_c;

  function automatic coord_t sub(input coord_t x, input coord_t y);
    return sat_w($signed({{2{x[CoordWidth-1]}}, x}) - $signed({{2{y[CoordWidth-1]}}, y}));
  endfunction

  function automatic coord_t add3(input coord_t x, input coord_t y, input coord_t z);
    return sat_w($signed({{2{x[CoordWidth-1]}}, x}) + $signed({{2{y[CoordWidth-1]}}, y})
                 + $signed({{2{z[CoordWidth-1]}}, z}));
  endfunction

  // per step: six products for one cross or dot level
  coord_t m0 [3], m1 [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m0[k] = '0;
      m1[k] = '0;
    end
    case (cmd.idx)
      3'd0: for (int k = 0; k < 3; k++) begin
        m0[k] = fmul(dir[(k+1)%3], e2_r[(k+2)%3]);
        m1[k] = fmul(dir[(k+2)%3], e2_r[(k+1)%3]);
      end
      3'd1: for (int k = 0; k < 3; k++) begin
        m0[k] = fmul(tv_r[(k+1)%3], e1_r[(k+2)%3]);
        m1[k] = fmul(tv_r[(k+2)%3], e1_r[(k+1)%3]);
      end
      3'd2: for (int k = 0; k < 3; k++) begin
        m0[k] = fmul(e1_r[k], pv_r[k]);
        m1[k] = fmul(tv_r[k], pv_r[k]);
      end
      3'd3: for (int k = 0; k < 3; k++) begin
        m0[k] = fmul(dir[k], qv_r[k]);
        m1[k] = fmul(e2_r[k], qv_r[k]);
      end
      default: ;
    endcase
  end

  // sign flip by det, kept exact at two extra bits
  logic signed [CoordWidth+1:0] det_x, nu_x, nv_x, nt_x;
  logic signed [CoordWidth+1:0] det_m, nu_m, nv_m, nt_m, uv_m;
  assign det_x = $signed({{2{det_r[CoordWidth-1]}}, det_r});
  assign nu_x  = $signed({{2{nu_r[CoordWidth-1]}}, nu_r});
  assign nv_x  = $signed({{2{nv_r[CoordWidth-1]}}, nv_r});
  assign nt_x  = $signed({{2{nt_r[CoordWidth-1]}}, nt_r});
  assign det_m = det_r[CoordWidth-1] ? -det_x : det_x;
  assign nu_m  = det_r[CoordWidth-1] ? -nu_x  : nu_x;
  assign nv_m  = det_r[CoordWidth-1] ? -nv_x  : nv_x;
  assign nt_m  = det_r[CoordWidth-1] ? -nt_x  : nt_x;
  assign uv_m  = nu_m + nv_m;

  logic reject_c;
  logic sat_c;
  assign reject_c = (det_m < $signed({1'b0, EpsQ})) || nu_m[CoordWidth+1] || (nu_m > det_m)
                    || nv_m[CoordWidth+1] || (uv_m > det_m)
                    || nt_m[CoordWidth+1] || (nt_m == '0);
  assign sat_c = {{IntBits{1'b0}}, nt_m[CoordWidth-1:0]}
                 >= {det_m[CoordWidth-1:0], {IntBits{1'b0}}};

  assign rsh     = {rem_r, num_r[TWidth-1]};
  assign rdif    = rsh - {1'b0, dd_r};
  assign qbit    = (rsh >= {1'b0, dd_r});
  assign div_end = rej_r || dsat_r || (dcnt_r == DivSteps);
  assign sts.div_done = div_end;
  assign sts.last     = last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= sub(vb[k], va[k]);
        e2_r[k] <= sub(vc[k], va[k]);
        tv_r[k] <= sub(org[k], va[k]);
      end
      last_r <= is_last;
    end
    if (cmd.step) begin
      for (int k = 0; k < 3; k++) begin
        p0_r[k] <= m0[k];
        p1_r[k] <= m1[k];
      end
      case (cmd.idx)
        3'd1: for (int k = 0; k < 3; k++) pv_r[k] <= sub(p0_r[k], p1_r[k]);
        3'd2: for (int k = 0; k < 3; k++) qv_r[k] <= sub(p0_r[k], p1_r[k]);
        3'd3: begin
          det_r <= add3(p0_r[0], p0_r[1], p0_r[2]);
          nu_r  <= add3(p1_r[0], p1_r[1], p1_r[2]);
        end
        3'd4: begin
          nv_r <= add3(p0_r[0], p0_r[1], p0_r[2]);
          nt_r <= add3(p1_r[0], p1_r[1], p1_r[2]);
        end
        default: ;
      endcase
    end
    if (cmd.div_start) begin
      rej_r  <= reject_c;
      dsat_r <= sat_c;
      rem_r  <= {{IntBits{1'b0}}, nt_m[CoordWidth-1:IntBits]};
      num_r  <= {nt_m[IntBits-1:0], {FracBits{1'b0}}};
      dd_r   <= det_m[CoordWidth-1:0];
      q_r    <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step && !div_end) begin
      // restoring long division of nt*2^frac by det, one quotient bit a cycle
      rem_r  <= qbit ? rdif[CoordWidth-1:0] : rsh[CoordWidth-1:0];
      num_r  <= {num_r[TWidth-2:0], 1'b0};
      q_r    <= {q_r[TWidth-2:0], qbit};
      dcnt_r <= dcnt_r + 5'd1;
    end
  end

  assign t_c      = dsat_r ? TMax : q_r;
  assign acc_c    = !rej_r && (t_c != '0);
  assign best_nxt = (acc_c && t_c < best_r) ? t_c : best_r;
  assign hit_nxt  = hit_r | acc_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r    <= TMax;
      hit_r     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.commit && last_r) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
      if (cmd.commit) begin
        if (last_r) begin
          res_t     <= best_nxt;
          res_hit   <= hit_nxt;
          best_r    <= TMax;
          hit_r     <= 1'b0;
        end else begin
          best_r <= best_nxt;
          hit_r  <= hit_nxt;
        end
      end
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid) else $error("result lost");
  a_nohit_max: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_hit |-> res_t == TMax) else $error("no hit but t set");
  a_rej_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !hit_r |-> best_r == TMax) else $error("best without hit");
endmodule
`default_nettype wire

// ===== hdl/ray_mesh_nearest_hit_top.sv =====
// ray_mesh_nearest_hit_top: nearest ray/triangle hit over a streamed mesh
// depends on rmnh_pkg, rmnh_if, rmnh_ctrl, rmnh_dp
//
// channel   dir   payload
// in        sink  a_x..c_z, is_last
// out       src   nearest_t, any_hit
// cfg       apb   origin, dir registers at 4*i
//
// a new triangle is accepted only after the previous one commits; per triangle:
// load, five product steps on six shared multipliers, a divider setup step,
// then 31 quotient bits at one a cycle (none if rejected or saturated), commit
// synchronous active-low reset; accumulators restart after each mesh
// the last triangle of a mesh waits at commit while the previous result is untaken
`default_nettype none
module ray_mesh_nearest_hit_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rmnh_tri_if.sink                            in_ch,
  rmnh_res_if.source                          out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [rmnh_pkg::AddrWidth-1:0] cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import rmnh_pkg::*;

  coord_t org_r [3], dir_r [3];
  coord_t va [3], vb [3], vc [3];
  cmd_t   cmd;
  sts_t   sts;
  logic   in_ready;
  logic [AddrWidth-3:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[AddrWidth-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        org_r[k] <= '0;
        dir_r[k] <= '0;
      end
      dir_r[2] <= coord_t'(1 << FracBits);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        RegOx: org_r[0] <= cfg_pwdata;
        RegOy: org_r[1] <= cfg_pwdata;
        RegOz: org_r[2] <= cfg_pwdata;
        RegDx: dir_r[0] <= cfg_pwdata;
        RegDy: dir_r[1] <= cfg_pwdata;
        RegDz: dir_r[2] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegOx: cfg_prdata = org_r[0];
      RegOy: cfg_prdata = org_r[1];
      RegOz: cfg_prdata = org_r[2];
      RegDx: cfg_prdata = dir_r[0];
      RegDy: cfg_prdata = dir_r[1];
      RegDz: cfg_prdata = dir_r[2];
      default: cfg_prdata = '0;
    endcase
  end

  assign va = '{in_ch.a_x, in_ch.a_y, in_ch.a_z};
  assign vb = '{in_ch.b_x, in_ch.b_y, in_ch.b_z};
  assign vc = '{in_ch.c_x, in_ch.c_y, in_ch.c_z};
  assign in_ch.ready = in_ready;

  rmnh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .out_busy(out_ch.valid),
    .sts, .in_ready, .cmd
  );

  rmnh_dp u_dp (
    .clk, .rst_n, .cmd, .org(org_r), .dir(dir_r), .va, .vb, .vc,
    .is_last(in_ch.is_last), .sts, .res_valid(out_ch.valid),
    .res_t(out_ch.nearest_t), .res_hit(out_ch.any_hit),
    .res_take(out_ch.ready)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for ray_mesh_nearest_hit_top, nearest hit over streamed meshes
// depends on rmnh_pkg, rmnh_if and the block under test; predicts every mesh result in place
`timescale 1ns / 1ps
module tb;
  import rmnh_pkg::*;

  localparam int  LIMIT = 1000000;
  localparam int  ONE   = 65536;
  localparam int  LATENCY_WAIT = 80;

  typedef struct {
    coord_t v[9];
    logic   last;
  } tri_item_t;

  typedef struct {
    dist_t t;
    logic  hit;
  } near_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [AddrWidth-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  rmnh_tri_if in_if ();
  rmnh_res_if out_if ();

  ray_mesh_nearest_hit_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tri_item_t tri_q[$];
  near_res_t near_q[$];
  longint ray_cfg[6];
  longint best_t;
  bit     hit_seen;
  int errors, meshes_done, hits_done, tris_sent, cycles;
  bit no_idle;
  int hold_req, hold_ack, hold_left;

  function automatic longint sat32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    p = p >>> FracBits;
    return sat32(p);
  endfunction

  function automatic void cross3(input longint x[3], input longint y[3], output longint r[3]);
    r[0] = sat32(qmul(x[1], y[2]) - qmul(x[2], y[1]));
    r[1] = sat32(qmul(x[2], y[0]) - qmul(x[0], y[2]));
    r[2] = sat32(qmul(x[0], y[1]) - qmul(x[1], y[0]));
  endfunction

  function automatic longint dot3(input longint x[3], input longint y[3]);
    return sat32(qmul(x[0], y[0]) + qmul(x[1], y[1]) + qmul(x[2], y[2]));
  endfunction

  function automatic bit ray_hits_tri(input tri_item_t it, output longint t);
    longint a[3], e1[3], e2[3], org[3], dir[3], pv[3], tv[3], qv[3];
    longint det, nu, nv, nt;
    t = 0;
    for (int k = 0; k < 3; k++) begin
      a[k]   = longint'(it.v[k]);
      e1[k]  = sat32(longint'(it.v[3+k]) - a[k]);
      e2[k]  = sat32(longint'(it.v[6+k]) - a[k]);
      org[k] = ray_cfg[k];
      dir[k] = ray_cfg[3+k];
      tv[k]  = sat32(org[k] - a[k]);
    end
    cross3(dir, e2, pv);
    det = dot3(e1, pv);
    if ((det < 0 ? -det : det) < longint'(EpsQ)) return 0;
    cross3(tv, e1, qv);
    nu = dot3(tv, pv);
    nv = dot3(dir, qv);
    nt = dot3(e2, qv);
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    if (nu < 0 || nu > det) return 0;
    if (nv < 0 || nu + nv > det) return 0;
    if (nt <= 0) return 0;
    t = (nt <<< FracBits) / det;
    if (t > longint'(TMax)) t = longint'(TMax);
    return t != 0;
  endfunction

  function automatic void predict_mesh(input tri_item_t it);
    longint t;
    if (ray_hits_tri(it, t)) begin
      hit_seen = 1;
      if (t < best_t) best_t = t;
    end
    if (it.last) begin
      near_q.push_back('{dist_t'(best_t), hit_seen});
      best_t = longint'(TMax);
      hit_seen = 0;
    end
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0h want %0h (mesh %0d)", what, got, want, meshes_done);
  endtask

  // driver
  int gap;
  tri_item_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap = 0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (in_if.valid) begin
        predict_mesh(cur);
        tris_sent++;
      end
      if (gap > 0) begin
        gap--;
        in_if.valid <= 1'b0;
      end else if (tri_q.size() > 0) begin
        cur = tri_q.pop_front();
        in_if.a_x <= cur.v[0]; in_if.a_y <= cur.v[1]; in_if.a_z <= cur.v[2];
        in_if.b_x <= cur.v[3]; in_if.b_y <= cur.v[4]; in_if.b_z <= cur.v[5];
        in_if.c_x <= cur.v[6]; in_if.c_y <= cur.v[7]; in_if.c_z <= cur.v[8];
        in_if.is_last <= cur.last;
        in_if.valid <= 1'b1;
        gap = no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (hold_req != hold_ack) begin
      hold_left <= 400;
      hold_ack <= hold_req;
    end
  end

  // monitor
  int stall;
  near_res_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (near_q.size() == 0) begin
          report("unexpected result", longint'(out_if.nearest_t), 0);
        end else begin
          want = near_q.pop_front();
          if (out_if.nearest_t !== want.t)
            report("nearest_t", longint'(out_if.nearest_t), longint'(want.t));
          if (out_if.any_hit !== want.hit)
            report("any_hit", longint'(out_if.any_hit), longint'(want.hit));
          if (want.hit) hits_done++;
        end
        meshes_done++;
        stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) out_if.ready <= 1'b0;
      else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(input logic [AddrWidth-3:0] idx, input longint val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val[31:0];
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    ray_cfg[idx] = longint'($signed(val[31:0]));
  endtask

  task automatic set_ray(input longint ox, oy, oz, dx, dy, dz);
    reg_write(RegOx, ox); reg_write(RegOy, oy); reg_write(RegOz, oz);
    reg_write(RegDx, dx); reg_write(RegDy, dy); reg_write(RegDz, dz);
  endtask

  task automatic push_tri(input longint ax, ay, az, bx, by, bz, cx, cy, cz, input bit last);
    tri_item_t it;
    it.v[0] = coord_t'(ax); it.v[1] = coord_t'(ay); it.v[2] = coord_t'(az);
    it.v[3] = coord_t'(bx); it.v[4] = coord_t'(by); it.v[5] = coord_t'(bz);
    it.v[6] = coord_t'(cx); it.v[7] = coord_t'(cy); it.v[8] = coord_t'(cz);
    it.last = last;
    tri_q.push_back(it);
  endtask

  function automatic longint soff(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic push_random_meshes(input int n);
    tri_item_t it;
    int mode, len, k;
    longint ctr;
    while (n > 0) begin
      len = $urandom_range(1, 6);
      for (int j = 0; j < len; j++) begin
        mode = $urandom_range(0, 99);
        k = $urandom_range(1, 20);
        for (int q = 0; q < 9; q++) begin
          if (mode < 60) begin
            ctr = ray_cfg[q % 3] + ray_cfg[3 + q % 3] * k;
            it.v[q] = coord_t'(ctr + soff(3 * ONE));
          end else if (mode < 80) it.v[q] = coord_t'(soff(8 * ONE));
          else it.v[q] = coord_t'($urandom());
        end
        it.last = (j == len - 1);
        tri_q.push_back(it);
      end
      n -= len;
    end
  endtask

  task automatic drain();
    while (tri_q.size() > 0 || in_if.valid || near_q.size() > 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  initial begin
    in_if.valid = 1'b0; in_if.is_last = 1'b0;
    in_if.a_x = '0; in_if.a_y = '0; in_if.a_z = '0;
    in_if.b_x = '0; in_if.b_y = '0; in_if.b_z = '0;
    in_if.c_x = '0; in_if.c_y = '0; in_if.c_z = '0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    hold_req = 0; hold_ack = 0; hold_left = 0; cycles = 0;
    no_idle = 0;
    ray_cfg = '{0, 0, 0, 0, 0, ONE};
    best_t = longint'(TMax);
    hit_seen = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (LATENCY_WAIT) @(posedge clk);

    // directed, reset ray along +z
    push_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE, 1);
    push_tri(2*ONE, -ONE, 5*ONE, 5*ONE, -ONE, 5*ONE, 2*ONE, 2*ONE, 5*ONE, 1);
    push_tri(-ONE, 2*ONE, 5*ONE, 2*ONE, 2*ONE, 5*ONE, -ONE, 5*ONE, 5*ONE, 1);
    push_tri(-ONE, -ONE, 5*ONE, ONE/4, ONE/4, 5*ONE, -ONE, 2*ONE, 5*ONE, 1);
    push_tri(-ONE, -ONE, -5*ONE, 2*ONE, -ONE, -5*ONE, -ONE, 2*ONE, -5*ONE, 1);
    push_tri(-ONE, -ONE, 0, 2*ONE, -ONE, 0, -ONE, 2*ONE, 0, 1);
    push_tri(-ONE, -ONE, 1, 2*ONE, -ONE, 1, -ONE, 2*ONE, 1, 1);
    push_tri(0, 0, 0, 0, ONE, 5*ONE, 0, 0, 7*ONE, 1);
    push_tri(ONE, ONE, ONE, ONE, ONE, ONE, 2*ONE, 3*ONE, 4*ONE, 1);
    push_tri(-2, -2, ONE, 3, -2, ONE, -2, 3, ONE, 1);
    push_tri(-ONE, -ONE, 9*ONE, 2*ONE, -ONE, 9*ONE, -ONE, 2*ONE, 9*ONE, 0);
    push_tri(-ONE, -ONE, 3*ONE, 2*ONE, -ONE, 3*ONE, -ONE, 2*ONE, 3*ONE, 0);
    push_tri(-ONE, -ONE, 6*ONE, 2*ONE, -ONE, 6*ONE, -ONE, 2*ONE, 6*ONE, 1);
    push_tri(-ONE, -ONE, 32767*ONE, 2*ONE, -ONE, 32767*ONE, -ONE, 2*ONE, 32767*ONE, 1);
    push_tri(VMax, VMax, VMax, VMax, VMax, VMax, VMax, VMax, VMax, 1);
    push_tri(VMin, VMin, VMin, VMin, VMin, VMin, VMin, VMin, VMin, 1);
    push_tri(VMin, VMin, VMax, VMax, VMin, VMax, VMin, VMax, VMax, 1);
    push_tri(VMax, VMax, VMin, VMin, VMax, VMin, VMax, VMin, VMin, 1);
    push_tri(VMin, VMax, VMin, VMax, VMin, VMax, VMin, VMax, VMin, 1);
    drain();

    set_ray(0, 0, 0, 0, 0, ONE);
    push_random_meshes(250);
    drain();

    set_ray(soff(2*ONE), soff(2*ONE), soff(2*ONE), soff(2*ONE), soff(2*ONE), soff(2*ONE));
    push_random_meshes(150);
    hold_req = 1;
    push_random_meshes(150);
    drain();

    // tiny direction drives t into saturation
    set_ray(0, 0, 0, 0, 0, 1);
    push_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE, 1);
    push_random_meshes(250);
    drain();

    set_ray(VMin, VMax, VMin, VMax, VMin, VMax);
    push_random_meshes(250);
    drain();

    set_ray(ONE, -ONE, 0, 0, 0, 0);
    push_random_meshes(150);
    drain();

    no_idle = 1;
    set_ray(soff(ONE), soff(ONE), soff(ONE), soff(ONE), soff(ONE), ONE + soff(ONE/2));
    push_random_meshes(300);
    drain();
    no_idle = 0;

    set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    push_random_meshes(250);
    drain();

    $display("sent %0d triangles in %0d meshes over eight ray settings", tris_sent, meshes_done);
    $display("%0d meshes reported a hit, %0d mismatches", hits_done, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
